FILE: rtl/core/m4i_pkg.sv
package m4i_pkg;

    localparam int ELEM_BITS_DEF = 16;
    localparam int THR_BITS      = 40;
    localparam int OUT_BITS      = 32;
    localparam int FRAC_SHIFT    = 25;
    localparam int QUO_BITS      = 33;
    localparam int N_TERMS       = 6;
    localparam logic [OUT_BITS-1:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic [2:0] {
        S_LOAD,
        S_COF,
        S_DET,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
        logic [1:0] c;
        logic [1:0] d;
        logic [1:0] e;
        logic [1:0] f;
        logic       neg;
    } t_term;

    typedef struct packed {
        logic       start_cof;
        logic       start_div;
        logic [1:0] row;
        logic       sing;
    } t_lane_ctl;

    typedef struct packed {
        logic cof_done;
        logic div_done;
        logic clip;
    } t_lane_sts;

    function automatic t_term term_offs(input logic [2:0] t);
        t_term r;
        case (t)
            3'd0: r = '{2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 1'b0};
            3'd1: r = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd1, 1'b0};
            3'd2: r = '{2'd1, 2'd3, 2'd2, 2'd1, 2'd3, 2'd2, 1'b0};
            3'd3: r = '{2'd3, 2'd1, 2'd2, 2'd2, 2'd1, 2'd3, 1'b1};
            3'd4: r = '{2'd3, 2'd2, 2'd2, 2'd3, 2'd1, 2'd1, 1'b1};
            3'd5: r = '{2'd3, 2'd3, 2'd2, 2'd1, 2'd1, 2'd2, 1'b1};
            default: r = '{2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 1'b0};
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/m4i_lane.sv
module m4i_lane
    import m4i_pkg::*;
#(
    parameter int         ELEM_BITS = ELEM_BITS_DEF,
    parameter logic [1:0] LANE      = 2'd0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [ELEM_BITS-1:0]   i_mat [4][4],
    input  t_lane_ctl                     i_ctl,
    input  logic [4*ELEM_BITS+1:0]        i_adet,
    input  logic                          i_det_neg,
    output t_lane_sts                     o_sts,
    output logic [OUT_BITS-1:0]           o_val,
    output logic signed [3*ELEM_BITS+1:0] o_cof [4]
);

    localparam int E  = ELEM_BITS;
    localparam int PW = 2 * E;
    localparam int TW = 3 * E;
    localparam int CW = 3 * E + 2;
    localparam int QW = 4 * E + 36;
    localparam int KW = $clog2(QUO_BITS + 1);

    t_term                tm;
    logic [1:0]           ra, rb, rc, ca, cb, cc;
    logic signed [E-1:0]  op_a, op_b, op_c;
    logic signed [TW-1:0] prod3;
    logic signed [CW-1:0] acc_next;

    logic                 r_cbusy, r_cdone, r_sub;
    logic [1:0]           r_j;
    logic [2:0]           r_t;
    logic signed [PW-1:0] r_p;
    logic signed [CW-1:0] r_acc;
    logic signed [CW-1:0] r_cof [4];

    logic signed [CW-1:0] cof_sel, cof_mag;
    logic [QW-1:0]        n_ext, d2;
    logic                 r_dbusy, r_ddone, r_ovf, r_neg, r_sing;
    logic [1:0]           r_row;
    logic [KW-1:0]        r_cnt;
    logic [QW-1:0]        r_rem, r_dsh;
    logic [QUO_BITS-1:0]  r_q;
    logic [QUO_BITS:0]    mag;
    logic [OUT_BITS-1:0]  val;
    logic                 clip;

    assign tm   = term_offs(r_t);
    assign ra   = LANE + tm.a;
    assign rb   = LANE + tm.c;
    assign rc   = LANE + tm.e;
    assign ca   = r_j + tm.b;
    assign cb   = r_j + tm.d;
    assign cc   = r_j + tm.f;
    assign op_a = i_mat[ra][ca];
    assign op_b = i_mat[rb][cb];
    assign op_c = i_mat[rc][cc];
    assign prod3    = r_p * op_c;
    assign acc_next = tm.neg ? (r_acc - CW'(prod3)) : (r_acc + CW'(prod3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy <= 1'b0;
            r_cdone <= 1'b0;
        end else begin
            r_cdone <= 1'b0;
            if (i_ctl.start_cof) begin
                r_cbusy <= 1'b1;
                r_j     <= 2'd0;
                r_t     <= 3'd0;
                r_sub   <= 1'b0;
                r_acc   <= '0;
            end else if (r_cbusy) begin
                if (!r_sub) begin
                    r_p   <= op_a * op_b;
                    r_sub <= 1'b1;
                end else begin
                    r_sub <= 1'b0;
                    if (r_t == 3'(N_TERMS - 1)) begin
                        r_cof[r_j] <= (LANE[0] ^ r_j[0]) ? -acc_next : acc_next;
                        r_acc      <= '0;
                        r_t        <= 3'd0;
                        if (r_j == 2'd3) begin
                            r_cbusy <= 1'b0;
                            r_cdone <= 1'b1;
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end else begin
                        r_acc <= acc_next;
                        r_t   <= r_t + 3'd1;
                    end
                end
            end
        end
    end

    assign cof_sel = r_cof[i_ctl.row];
    assign cof_mag = cof_sel[CW-1] ? -cof_sel : cof_sel;
    assign n_ext   = (QW'($unsigned(cof_mag)) << FRAC_SHIFT) + QW'(i_adet);
    assign d2      = QW'(i_adet) << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_ctl.start_div) begin
                r_dbusy <= 1'b1;
                r_rem   <= n_ext;
                r_dsh   <= d2 << (QUO_BITS - 1);
                r_ovf   <= n_ext >= (d2 << QUO_BITS);
                r_cnt   <= KW'(QUO_BITS);
                r_q     <= '0;
                r_neg   <= cof_sel[CW-1] ^ i_det_neg;
                r_row   <= i_ctl.row;
                r_sing  <= i_ctl.sing;
            end else if (r_dbusy) begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[QUO_BITS-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QUO_BITS-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        mag  = r_ovf ? {1'b1, {QUO_BITS{1'b0}}} : {1'b0, r_q};
        clip = 1'b0;
        if (!r_neg && mag > (QUO_BITS+1)'(32'h7FFF_FFFF)) begin
            mag  = (QUO_BITS+1)'(32'h7FFF_FFFF);
            clip = 1'b1;
        end else if (r_neg && mag > (QUO_BITS+1)'(32'h8000_0000)) begin
            mag  = (QUO_BITS+1)'(32'h8000_0000);
            clip = 1'b1;
        end
        val = r_neg ? (OUT_BITS'(0) - mag[OUT_BITS-1:0]) : mag[OUT_BITS-1:0];
        if (r_sing) begin
            val  = (r_row == LANE) ? ONE_Q16 : '0;
            clip = 1'b0;
        end
    end

    assign o_val        = val;
    assign o_sts.cof_done = r_cdone;
    assign o_sts.div_done = r_ddone;
    assign o_sts.clip     = clip;
    assign o_cof        = r_cof;

endmodule

FILE: rtl/core/m4i_merge.sv
module m4i_merge
    import m4i_pkg::*;
#(
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [3*ELEM_BITS+1:0] i_cof [4],
    input  logic signed [ELEM_BITS-1:0]   i_row0 [4],
    input  logic [THR_BITS-1:0]           i_thr,
    output logic                          o_done,
    output logic [4*ELEM_BITS+1:0]        o_adet,
    output logic                          o_det_neg,
    output logic                          o_sing
);

    localparam int E    = ELEM_BITS;
    localparam int CW   = 3 * E + 2;
    localparam int L    = CW / 2;
    localparam int DW   = 4 * E + 3;
    localparam int AW   = 4 * E + 2;
    localparam int CMPW = (AW > THR_BITS) ? AW : THR_BITS;

    logic                   r_busy, r_pv, r_done, r_neg, r_sing;
    logic [2:0]             r_step;
    logic signed [L+E:0]    r_plo;
    logic signed [CW-L+E-1:0] r_phi;
    logic signed [DW-1:0]   r_det;
    logic [AW-1:0]          r_adet;
    logic signed [CW-1:0]   cof;
    logic signed [E-1:0]    el;
    logic signed [DW-1:0]   term, det_abs;

    assign cof     = i_cof[r_step[1:0]];
    assign el      = i_row0[r_step[1:0]];
    assign term    = (DW'(r_phi) <<< L) + DW'(r_plo);
    assign det_abs = r_det[DW-1] ? -r_det : r_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
                r_det  <= '0;
                r_pv   <= 1'b0;
            end else if (r_busy) begin
                if (r_step < 3'd4) begin
                    r_plo <= $signed({1'b0, cof[L-1:0]}) * el;
                    r_phi <= $signed(cof[CW-1:L]) * el;
                    r_pv  <= 1'b1;
                end else begin
                    r_pv  <= 1'b0;
                end
                if (r_pv) begin
                    r_det <= r_det + term;
                end
                r_step <= r_step + 3'd1;
                if (r_step == 3'd5) begin
                    r_adet <= det_abs[AW-1:0];
                    r_neg  <= r_det[DW-1];
                    r_sing <= CMPW'(det_abs[AW-1:0]) <= CMPW'(i_thr);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_adet    = r_adet;
    assign o_det_neg = r_neg;
    assign o_sing    = r_sing;

endmodule

FILE: rtl/core/matrix4_inverse_adjugate_top.sv
// 4x4 matrix inverse by cofactors and adjugate.
// Input channel: one matrix row per request (i_elem0..i_elem3, signed Q8.8),
// taken when i_valid is high and o_stall is low. Rows arrive in order 0..3.
// After the fourth row the block raises o_stall and works on the matrix.
// Four lanes, one per cofactor row, form the sixteen 3x3 cofactors with one
// shared multiplier pair per lane. A merge stage then forms the determinant
// and compares it to the threshold register. For each inverse row the four
// lanes then run restoring dividers, one quotient bit per cycle, in parallel.
// Output channel: four rows per matrix with o_out_row, o_last, o_singular
// and o_clipped, offered when o_valid is high and taken when i_stall is low.
// A stalled row holds until it is taken; the next row starts afterwards.
// A new matrix is taken only after the last result row of the previous one.
// Reset clears the row count and the threshold; the matrix store is not
// cleared. i_cfg_we writes i_cfg_data into the threshold register.
module matrix4_inverse_adjugate_top
    import m4i_pkg::*;
#(
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [THR_BITS-1:0]         i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [ELEM_BITS-1:0] i_elem0,
    input  logic signed [ELEM_BITS-1:0] i_elem1,
    input  logic signed [ELEM_BITS-1:0] i_elem2,
    input  logic signed [ELEM_BITS-1:0] i_elem3,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [OUT_BITS-1:0]  o_inv0,
    output logic signed [OUT_BITS-1:0]  o_inv1,
    output logic signed [OUT_BITS-1:0]  o_inv2,
    output logic signed [OUT_BITS-1:0]  o_inv3,
    output logic [1:0]                  o_out_row,
    output logic                        o_last,
    output logic                        o_singular,
    output logic                        o_clipped
);

    localparam int CW = 3 * ELEM_BITS + 2;
    localparam int AW = 4 * ELEM_BITS + 2;

    t_state                     r_state, n_state;
    logic [1:0]                 r_row_cnt, r_orow, n_orow;
    logic [THR_BITS-1:0]        r_thr;
    logic signed [ELEM_BITS-1:0] r_mat [4][4];
    logic [OUT_BITS-1:0]        r_inv [4];
    logic                       r_clip;
    t_lane_ctl                  ctl;
    t_lane_sts                  sts [4];
    logic [OUT_BITS-1:0]        lane_val [4];
    logic signed [CW-1:0]       lane_cof [4][4];
    logic                       mrg_start, mrg_done, det_neg, sing;
    logic [AW-1:0]              adet;
    logic                       in_acc, out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_row_cnt <= 2'd0;
            r_thr     <= '0;
            r_orow    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_orow  <= n_orow;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (in_acc) begin
                r_row_cnt <= r_row_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mat[r_row_cnt][0] <= i_elem0;
            r_mat[r_row_cnt][1] <= i_elem1;
            r_mat[r_row_cnt][2] <= i_elem2;
            r_mat[r_row_cnt][3] <= i_elem3;
        end
        if (sts[0].div_done) begin
            r_inv  <= lane_val;
            r_clip <= sts[0].clip | sts[1].clip | sts[2].clip | sts[3].clip;
        end
    end

    always_comb begin
        n_state = r_state;
        n_orow  = r_orow;
        case (r_state)
            S_LOAD: begin
                if (in_acc && r_row_cnt == 2'd3) begin
                    n_state = S_COF;
                end
            end
            S_COF: begin
                if (sts[0].cof_done) begin
                    n_state = S_DET;
                end
            end
            S_DET: begin
                if (mrg_done) begin
                    n_state = S_DIV;
                    n_orow  = 2'd0;
                end
            end
            S_DIV: begin
                if (sts[0].div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    n_orow  = r_orow + 2'd1;
                    n_state = (r_orow == 2'd3) ? S_LOAD : S_DIV;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        ctl.start_cof = (r_state == S_LOAD) && in_acc && (r_row_cnt == 2'd3);
        ctl.start_div = ((r_state == S_DET) && mrg_done) ||
                        ((r_state == S_OUT) && out_acc && (r_orow != 2'd3));
        ctl.row       = n_orow;
        ctl.sing      = sing;
        mrg_start     = (r_state == S_COF) && sts[0].cof_done;
        o_stall       = (r_state != S_LOAD);
        o_valid       = (r_state == S_OUT);
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        m4i_lane #(
            .ELEM_BITS (ELEM_BITS),
            .LANE      (2'(g))
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_mat     (r_mat),
            .i_ctl     (ctl),
            .i_adet    (adet),
            .i_det_neg (det_neg),
            .o_sts     (sts[g]),
            .o_val     (lane_val[g]),
            .o_cof     (lane_cof[g])
        );
    end

    m4i_merge #(
        .ELEM_BITS (ELEM_BITS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mrg_start),
        .i_cof     (lane_cof[0]),
        .i_row0    (r_mat[0]),
        .i_thr     (r_thr),
        .o_done    (mrg_done),
        .o_adet    (adet),
        .o_det_neg (det_neg),
        .o_sing    (sing)
    );

    assign o_inv0     = r_inv[0];
    assign o_inv1     = r_inv[1];
    assign o_inv2     = r_inv[2];
    assign o_inv3     = r_inv[3];
    assign o_out_row  = r_orow;
    assign o_last     = (r_orow == 2'd3);
    assign o_singular = sing;
    assign o_clipped  = r_clip;

    a_out_stalls_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("Input taken while a result row is pending.");

    a_row_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_last) |=> !o_valid)
        else $error("Next result row offered without a division.");

    a_sing_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> !o_clipped)
        else $error("Singular row marked as clipped.");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> (r_state == S_LOAD && r_row_cnt == 2'd0))
        else $error("Block not ready for a new matrix after the last row.");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import m4i_pkg::*;

    typedef struct {
        logic signed [31:0] inv [4];
        logic [1:0]         row;
        logic               last;
        logic               singular;
        logic               clipped;
    } t_inv_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [39:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_elem0, i_elem1, i_elem2, i_elem3;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_inv0, o_inv1, o_inv2, o_inv3;
    logic [1:0]         o_out_row;
    logic               o_last, o_singular, o_clipped;

    matrix4_inverse_adjugate_top dut (.*);

    logic signed [15:0] mat [4][4];
    logic [1:0]         load_row;
    logic [39:0]        sing_thr;
    t_inv_row           inv_rows_due [$];
    int                 fail_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_off;
    longint             cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [47:0] minor3(int i, int j);
        logic signed [47:0] s;
        int a [6][7];
        s = 0;
        a = '{'{1, 1, 2, 2, 3, 3, 0}, '{1, 2, 2, 3, 3, 1, 0}, '{1, 3, 2, 1, 3, 2, 0},
              '{3, 1, 2, 2, 1, 3, 1}, '{3, 2, 2, 3, 1, 1, 1}, '{3, 3, 2, 1, 1, 2, 1}};
        for (int t = 0; t < 6; t++) begin
            logic signed [47:0] p;
            p = 48'(mat[(i + a[t][0]) % 4][(j + a[t][1]) % 4])
                * 48'(mat[(i + a[t][2]) % 4][(j + a[t][3]) % 4])
                * 48'(mat[(i + a[t][4]) % 4][(j + a[t][5]) % 4]);
            s = a[t][6] ? s - p : s + p;
        end
        return ((i + j) % 2) ? -s : s;
    endfunction

    task automatic predict_inverse();
        logic signed [47:0]  cof [4][4];
        logic signed [127:0] det;
        logic [127:0]        adet, n, q;
        logic [32:0]         mag;
        t_inv_row            r;
        logic                sing, neg;
        det = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                cof[i][j] = minor3(i, j);
        for (int j = 0; j < 4; j++)
            det += 128'(cof[0][j]) * 128'(mat[0][j]);
        adet = det < 0 ? -det : det;
        sing = adet <= {88'd0, sing_thr};
        for (int rr = 0; rr < 4; rr++) begin
            r.clipped = 1'b0;
            for (int c = 0; c < 4; c++) begin
                if (sing) begin
                    r.inv[c] = (rr == c) ? ONE_Q16 : 32'd0;
                end else begin
                    neg = (cof[c][rr] < 0) != (det < 0);
                    n = cof[c][rr] < 0 ? -128'(cof[c][rr]) : 128'(cof[c][rr]);
                    q = ((n << 25) + adet) / (adet << 1);
                    mag = q[127:32] != 0 ? 33'h1_0000_0000 : {1'b0, q[31:0]};
                    if (!neg && mag > 33'h7FFF_FFFF) begin
                        mag = 33'h7FFF_FFFF;
                        r.clipped = 1'b1;
                    end else if (neg && mag > 33'h8000_0000) begin
                        mag = 33'h8000_0000;
                        r.clipped = 1'b1;
                    end
                    r.inv[c] = neg ? -mag[31:0] : mag[31:0];
                end
            end
            r.row = rr[1:0];
            r.last = rr == 3;
            r.singular = sing;
            inv_rows_due.push_back(r);
        end
    endtask

    task automatic send_row(logic signed [15:0] e0, e1, e2, e3);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_elem0, i_elem1, i_elem2, i_elem3} <= {e0, e1, e2, e3};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mat[load_row] = '{e0, e1, e2, e3};
        if (load_row == 3) predict_inverse();
        load_row++;
    endtask

    task automatic send_matrix(logic signed [15:0] m [4][4]);
        for (int r = 0; r < 4; r++) send_row(m[r][0], m[r][1], m[r][2], m[r][3]);
    endtask

    task automatic send_random_matrix(int kind);
        logic signed [15:0] m [4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                case (kind)
                    0: m[r][c] = 16'($urandom);
                    1: m[r][c] = 16'((r == c ? 256 : 0) + int'($urandom_range(255)) - 128);
                    default: m[r][c] = 16'(int'($urandom_range(2047)) - 1024);
                endcase
        send_matrix(m);
    endtask

    task automatic drain_and_wait();
        i_valid <= 1'b0;
        while (inv_rows_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [39:0] v);
        drain_and_wait();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sing_thr = v;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (inv_rows_due.size() == 0) begin
                $error("result row with nothing expected");
                fail_count++;
            end else begin
                t_inv_row x;
                x = inv_rows_due.pop_front();
                if (o_inv0 !== x.inv[0]) begin
                    $error("inv0 exp %h got %h", x.inv[0], o_inv0); fail_count++;
                end
                if (o_inv1 !== x.inv[1]) begin
                    $error("inv1 exp %h got %h", x.inv[1], o_inv1); fail_count++;
                end
                if (o_inv2 !== x.inv[2]) begin
                    $error("inv2 exp %h got %h", x.inv[2], o_inv2); fail_count++;
                end
                if (o_inv3 !== x.inv[3]) begin
                    $error("inv3 exp %h got %h", x.inv[3], o_inv3); fail_count++;
                end
                if (o_out_row !== x.row) begin
                    $error("out_row exp %0d got %0d", x.row, o_out_row); fail_count++;
                end
                if (o_last !== x.last) begin
                    $error("last exp %0d got %0d", x.last, o_last); fail_count++;
                end
                if (o_singular !== x.singular) begin
                    $error("singular exp %0d got %0d", x.singular, o_singular);
                    fail_count++;
                end
                if (o_clipped !== x.clipped) begin
                    $error("clipped exp %0d got %0d", x.clipped, o_clipped); fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    task automatic test_directed();
        logic signed [15:0] m [4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = r == c ? 16'sh0100 : 16'sh0000;
        send_matrix(m);
        m[2][2] = 16'sh0001;
        send_matrix(m);
        m = '{'{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000},
              '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000},
              '{16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000},
              '{16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF}};
        send_matrix(m);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = 16'(256 * (r + 1));
        send_matrix(m);
        m = '{'{16'shFFFF, 16'sh7FFF, 16'sh8000, 16'sh5555},
              '{16'shAAAA, 16'sh0001, 16'sh1234, 16'shFEDC},
              '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh0000},
              '{16'sh00FF, 16'shFF00, 16'sh0F0F, 16'shF0F0}};
        send_matrix(m);
        drain_and_wait();
    endtask

    task automatic test_threshold();
        logic signed [15:0] m [4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = r == c ? 16'sh0100 : 16'sh0000;
        write_threshold(40'h01_0000_0000);
        send_matrix(m);
        write_threshold(40'h00_FFFF_FFFF);
        send_matrix(m);
        write_threshold('1);
        send_random_matrix(0);
        send_random_matrix(2);
        write_threshold(40'h00_0001_0000);
        send_random_matrix(1);
        write_threshold(0);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) send_random_matrix($urandom_range(2));
    endtask

    task automatic test_backpressure();
        send_random_matrix(1);
        hold_off = 400;
        send_random_matrix(1);
        send_random_matrix(0);
        drain_and_wait();
        send_random_matrix(2);
    endtask

    initial begin
        cycle_count = 0;
        fail_count = 0;
        hold_off = 0;
        load_row = 0;
        sing_thr = 0;
        send_idle_pct = 6;
        recv_idle_pct = 61;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        {i_elem0, i_elem1, i_elem2, i_elem3} = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_threshold();
        test_random(16);
        test_backpressure();
        drain_and_wait();
        send_idle_pct = 61;
        recv_idle_pct = 6;
        test_random(16);
        drain_and_wait();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(16);
        drain_and_wait();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: matrix4_inverse_adjugate_top.f
rtl/core/m4i_pkg.sv
rtl/core/m4i_lane.sv
rtl/core/m4i_merge.sv
rtl/core/matrix4_inverse_adjugate_top.sv
test/tb_top.sv
